// ===== rtl/sffp_pkg.sv =====
// ----------------------------------------------------------------------------
// Servo feedback frame parser package
// Shared widths, header constants, status codes and link types.
// ----------------------------------------------------------------------------
package sffp_pkg;

  // Frame geometry.
  localparam int unsigned WinLen   = 8;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned WordW    = 16;
  localparam int unsigned StatusW  = 2;

  // Header bytes and the mask applied to the id of a good frame.
  localparam logic [ByteW-1:0] HdrFirst  = 8'h55;
  localparam logic [ByteW-1:0] HdrSecond = 8'hAA;
  localparam logic [ByteW-1:0] IdMask    = 8'h0F;

  // Valid motor ids.
  localparam logic [ByteW-1:0] MotorIdOne = 8'd1;
  localparam logic [ByteW-1:0] MotorIdTwo = 8'd2;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    StOk     = 2'd0,
    StBadSum = 2'd1,
    StBadId  = 2'd2
  } status_e;

  // One window entry as it travels down the cell chain.
  typedef struct packed {
    logic             vld;
    logic [ByteW-1:0] data;
  } tap_t;

  // Outcome of checking one candidate window.
  typedef struct packed {
    logic             hit;
    status_e          status;
    logic [WordW-1:0] position;
    logic [WordW-1:0] motor_current;
    logic [ByteW-1:0] motor_id;
  } check_t;

endpackage

// ===== rtl/sffp_cell.sv =====
// ----------------------------------------------------------------------------
// Window cell
// Holds one received byte and its valid bit; takes its neighbor's entry on a
// shift and drops its valid bit on a clear.
// ----------------------------------------------------------------------------
module sffp_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  logic          clear_i,
  input  sffp_pkg::tap_t tap_i,
  output sffp_pkg::tap_t tap_o
);
  import sffp_pkg::*;

  logic             vld_d, vld_q;
  logic [ByteW-1:0] data_d, data_q;

  // A clear wins over a shift; data is don't-care once the valid bit drops.
  always_comb begin
    vld_d  = vld_q;
    data_d = data_q;
    if (clear_i) begin
      vld_d = 1'b0;
    end else if (shift_i) begin
      vld_d  = tap_i.vld;
      data_d = tap_i.data;
    end
  end

  // The valid bit is control state and is reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // The data byte needs no reset.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign tap_o.vld  = vld_q;
  assign tap_o.data = data_q;

endmodule

// ===== rtl/sffp_frame_check.sv =====
// ----------------------------------------------------------------------------
// Frame checker
// Tests the window that results from the incoming byte for a header, a good
// checksum and a valid motor id, and unpacks the payload fields.
// ----------------------------------------------------------------------------
module sffp_frame_check (
  input  logic [sffp_pkg::WinLen-1:0][sffp_pkg::ByteW-1:0] win_i,
  input  logic                                            full_i,
  output sffp_pkg::check_t                                chk_o
);
  import sffp_pkg::*;

  logic [ByteW-1:0] sum;
  logic [ByteW-1:0] id;
  logic             hdr_ok;
  status_e          status;

  // Additive checksum over bytes two to six, modulo 256.
  assign sum = win_i[2] + win_i[3] + win_i[4] + win_i[5] + win_i[6];
  assign id  = win_i[6];

  assign hdr_ok = (win_i[0] == HdrFirst) && (win_i[1] == HdrSecond);

  // The checksum is tested before the id.
  always_comb begin
    if (sum != win_i[7]) begin
      status = StBadSum;
    end else if ((id != MotorIdOne) && (id != MotorIdTwo)) begin
      status = StBadId;
    end else begin
      status = StOk;
    end
  end

  // Little-endian payload; error results keep the id byte as received.
  always_comb begin
    chk_o.hit           = full_i && hdr_ok;
    chk_o.status        = status;
    chk_o.position      = {win_i[3], win_i[2]};
    chk_o.motor_current = {win_i[5], win_i[4]};
    chk_o.motor_id      = (status == StOk) ? (id & IdMask) : id;
  end

endmodule

// ===== rtl/servo_feedback_frame_parser.sv =====
// ----------------------------------------------------------------------------
// Servo feedback frame parser
// Finds 8-byte feedback frames in a serial byte stream and reports them.
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle while the result register is
// empty or draining, and reports a result in the cycle after the byte that
// completes a candidate frame (header 0x55 0xAA in the oldest two of the last
// eight bytes). The rate is one byte per clock in that case: the window is a
// chain of eight cells that shift on every transfer, and the frame check is
// done on the shifted window in the same cycle, with a single output register
// that refills on the cycle it is taken. A good frame (status 0) empties the
// window, so the next frame needs eight fresh bytes; a bad frame (status 1
// checksum, 2 motor id) leaves the window to slide on. No result appears
// until eight bytes have arrived since reset or since the last good frame.
// ----------------------------------------------------------------------------
module servo_feedback_frame_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Byte input channel.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sffp_pkg::ByteW-1:0]    rx_byte_i,
  // Result channel.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sffp_pkg::StatusW-1:0]  status_o,
  output logic [sffp_pkg::WordW-1:0]    position_o,
  output logic [sffp_pkg::WordW-1:0]    motor_current_o,
  output logic [sffp_pkg::ByteW-1:0]    motor_id_o
);
  import sffp_pkg::*;

  tap_t                          taps [WinLen];
  tap_t                          feed [WinLen];
  logic [WinLen-1:0][ByteW-1:0]  next_win;
  logic                          in_xfer;
  logic                          clear;
  check_t                        chk;

  logic                          out_vld_d, out_vld_q;
  check_t                        res_d, res_q;

  // A new byte is taken whenever the result register is empty or draining.
  assign in_ready_o = !out_vld_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  // The newest byte enters the last cell; each cell feeds the one below it.
  always_comb begin
    for (int i = 0; i < WinLen - 1; i++) begin
      feed[i] = taps[i+1];
    end
    feed[WinLen-1].vld  = 1'b1;
    feed[WinLen-1].data = rx_byte_i;
  end

  // Window as it stands after this transfer's shift.
  always_comb begin
    for (int i = 0; i < WinLen; i++) begin
      next_win[i] = feed[i].data;
    end
  end

  // Cell chain holding the byte window.
  for (genvar g = 0; g < WinLen; g++) begin : g_cell
    sffp_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (in_xfer),
      .clear_i (clear),
      .tap_i   (feed[g]),
      .tap_o   (taps[g])
    );
  end

  // The window is full after the shift when the oldest incoming entry is valid.
  sffp_frame_check u_check (
    .win_i  (next_win),
    .full_i (feed[0].vld),
    .chk_o  (chk)
  );

  // A good frame empties the window.
  assign clear = in_xfer && chk.hit && (chk.status == StOk);

  // Result register: load on a hit, drop when taken.
  always_comb begin
    out_vld_d = out_vld_q;
    res_d     = res_q;
    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (in_xfer && chk.hit) begin
      out_vld_d = 1'b1;
      res_d     = chk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o     = out_vld_q;
  assign status_o        = res_q.status;
  assign position_o      = res_q.position;
  assign motor_current_o = res_q.motor_current;
  assign motor_id_o      = res_q.motor_id;

endmodule

// ===== tb/sv/servo_feedback_frame_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo feedback frame parser testbench
// Streams serial bytes into the parser: a few hand-built frames first, then
// random frames, corrupted frames, cut-off frames and line noise. A scoreboard
// keeps its own copy of the eight-byte window and predicts every report. The
// byte and result sides both idle and stall at random.
// ----------------------------------------------------------------------------
module servo_feedback_frame_parser_tb;
  import sffp_pkg::*;

  localparam int unsigned MaxGap       = 11;
  localparam int unsigned RandomBytes  = 1300;
  localparam int unsigned StallLimit   = 1000;
  localparam int unsigned SettleCycles = 16;

  // One expected frame report.
  typedef struct packed {
    status_e          status;
    logic [WordW-1:0] position;
    logic [WordW-1:0] motor_current;
    logic [ByteW-1:0] motor_id;
  } frame_report_t;

  // Tracks the receive window and the reports still owed by the parser.
  class frame_scoreboard;
    logic [ByteW-1:0] window [WinLen];
    int unsigned      fill;
    frame_report_t    owed[$];
    int unsigned      fail_count;

    function new();
      fail_count = 0;
      clear_window();
    endfunction

    function void clear_window();
      foreach (window[i]) window[i] = '0;
      fill = 0;
    endfunction

    // Shift one transferred byte in and queue the report it completes, if any.
    function void note_byte(logic [ByteW-1:0] rx);
      logic [ByteW-1:0] sum;
      frame_report_t    rep;
      for (int i = 0; i < WinLen - 1; i++) window[i] = window[i + 1];
      window[WinLen - 1] = rx;
      if (fill < WinLen) fill++;
      if (fill < WinLen || window[0] != HdrFirst || window[1] != HdrSecond) return;

      sum = window[2] + window[3] + window[4] + window[5] + window[6];
      rep.position      = {window[3], window[2]};
      rep.motor_current = {window[5], window[4]};
      // The checksum is judged before the motor id.
      if (sum != window[7]) rep.status = StBadSum;
      else if (window[6] != MotorIdOne && window[6] != MotorIdTwo) rep.status = StBadId;
      else rep.status = StOk;
      rep.motor_id = (rep.status == StOk) ? (window[6] & IdMask) : window[6];
      owed.push_back(rep);
      // A good frame empties the window; a bad one lets the scan slide on.
      if (rep.status == StOk) clear_window();
    endfunction

    // Compare one transferred report with the oldest one owed.
    function void check_report(logic [StatusW-1:0] st, logic [WordW-1:0] pos,
                               logic [WordW-1:0] cur, logic [ByteW-1:0] id);
      frame_report_t exp_rep;
      if (owed.size() == 0) begin
        $error("unexpected report: status %0d position %h current %h id %h",
               st, pos, cur, id);
        fail_count++;
        return;
      end
      exp_rep = owed.pop_front();
      if (st !== exp_rep.status) begin
        $error("status: expected %0d, got %0d", exp_rep.status, st);
        fail_count++;
      end
      if (pos !== exp_rep.position) begin
        $error("position: expected %h, got %h", exp_rep.position, pos);
        fail_count++;
      end
      if (cur !== exp_rep.motor_current) begin
        $error("motor_current: expected %h, got %h", exp_rep.motor_current, cur);
        fail_count++;
      end
      if (id !== exp_rep.motor_id) begin
        $error("motor_id: expected %h, got %h", exp_rep.motor_id, id);
        fail_count++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n         = 1'b0;
  logic                in_valid      = 1'b0;
  logic                in_ready;
  logic [ByteW-1:0]    rx_byte       = '0;
  logic                out_valid;
  logic                out_ready     = 1'b0;
  logic [StatusW-1:0]  status;
  logic [WordW-1:0]    position;
  logic [WordW-1:0]    motor_current;
  logic [ByteW-1:0]    motor_id;

  frame_scoreboard sb = new();
  int unsigned     bytes_sent   = 0;
  int unsigned     stall_cycles = 0;
  bit              src_calm     = 1'b0;
  bit              sink_calm    = 1'b0;

  servo_feedback_frame_parser dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .rx_byte_i       (rx_byte),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .status_o        (status),
    .position_o      (position),
    .motor_current_o (motor_current),
    .motor_id_o      (motor_id)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Idle cycles before the next item; calm stretches have none.
  function automatic int unsigned draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, MaxGap);
  endfunction

  // A 16-bit field value that often sits at an extreme.
  function automatic logic [WordW-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return WordW'($urandom);
    endcase
  endfunction

  // Offer one byte and wait for its transfer.
  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    if ($urandom_range(0, 49) == 0) src_calm = !src_calm;
    gap = draw_gap(src_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Send the first len bytes of a frame; sum_err is added to the checksum.
  task automatic send_frame(input logic [WordW-1:0] pos, input logic [WordW-1:0] cur,
                            input logic [ByteW-1:0] id, input logic [ByteW-1:0] sum_err,
                            input int unsigned len);
    logic [ByteW-1:0] frame [WinLen];
    frame[0] = HdrFirst;
    frame[1] = HdrSecond;
    frame[2] = pos[7:0];
    frame[3] = pos[15:8];
    frame[4] = cur[7:0];
    frame[5] = cur[15:8];
    frame[6] = id;
    frame[7] = frame[2] + frame[3] + frame[4] + frame[5] + frame[6] + sum_err;
    for (int i = 0; i < len; i++) send_byte(frame[i]);
  endtask

  // Result side: stall at random, then take one report.
  initial begin
    int unsigned gap;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 49) == 0) sink_calm = !sink_calm;
      gap = draw_gap(sink_calm);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Observe transfers on both channels; bytes are noted before reports.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_byte(rx_byte);
      if (out_valid && out_ready) sb.check_report(status, position, motor_current, motor_id);
    end
  end

  // Give up when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == StallLimit) begin
      $display("FAIL servo_feedback_frame_parser");
      $finish;
    end
  end

  // Reset, directed frames, random traffic, drain and verdict.
  initial begin
    int unsigned      pick;
    logic [ByteW-1:0] id;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Good frames at both motor ids and at the field extremes.
    send_frame('1, '1, MotorIdOne, 8'h00, WinLen);
    send_frame('0, '0, MotorIdTwo, 8'h00, WinLen);
    // Checksum and id both wrong: the checksum wins.
    send_frame(16'h1234, 16'hABCD, 8'hFF, 8'h01, WinLen);
    // Good checksum with a bad id; the window then slides over it.
    send_frame(16'h8001, 16'h7FFE, 8'h00, 8'h00, WinLen);

    // Mostly frames with random content, the rest corruption and noise.
    while (bytes_sent < RandomBytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_frame(pick_word(), pick_word(), ByteW'($urandom_range(1, 2)), 8'h00, WinLen);
      end else if (pick < 60) begin
        send_frame(pick_word(), pick_word(), ByteW'($urandom),
                   ByteW'($urandom_range(1, 255)), WinLen);
      end else if (pick < 72) begin
        id = ByteW'($urandom_range(0, 253));
        if (id >= MotorIdOne) id = id + 8'd2;
        send_frame(pick_word(), pick_word(), id, 8'h00, WinLen);
      end else if (pick < 84) begin
        send_frame(pick_word(), pick_word(), ByteW'($urandom_range(1, 2)), 8'h00,
                   $urandom_range(1, WinLen - 1));
      end else begin
        // Line noise, rich in header bytes.
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 3) == 0) begin
            send_byte($urandom_range(0, 1) ? HdrFirst : HdrSecond);
          end else begin
            send_byte(ByteW'($urandom));
          end
        end
      end
    end
    in_valid <= 1'b0;

    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("PASS servo_feedback_frame_parser");
    end else begin
      $display("FAIL servo_feedback_frame_parser");
    end
    $finish;
  end

endmodule
